// ===== hw/rtl/gaussian_blur_stream_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian blur stream block
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_STREAM_MACROS_SVH
`define GAUSSIAN_BLUR_STREAM_MACROS_SVH

// same-cycle implication
`define GBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants, register indexes, state and control types of the blur.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_CHANNELS   = 3;
  localparam int DEF_COEF_BITS  = 16;

  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 8;
  localparam int HGT_W      = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int NUM_COEF   = 4;

  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd256;
  localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd256;
  localparam logic [1:0]  RST_KERNEL_RADIUS = 2'd1;
  localparam logic [16:0] RST_COEF_CENTER   = 17'd26346;
  localparam logic [16:0] RST_COEF_OFF1     = 17'd19595;
  localparam logic [16:0] RST_COEF_OFF2     = 17'd0;
  localparam logic [16:0] RST_COEF_OFF3     = 17'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_RADIUS = 3'd2,
    REG_COEF_CENTER   = 3'd3,
    REG_COEF_OFF1     = 3'd4,
    REG_COEF_OFF2     = 3'd5,
    REG_COEF_OFF3     = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2,
    ST_FIN   = 2'd3
  } gbs_state_t;

  typedef struct packed {
    logic clr;
    logic tap_ok;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/gbs_line_store.sv =====
// ----------------------------------------------------------------------------
// gbs_line_store
// Ring of image rows: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbs_line_store #(
  parameter int DEPTH  = 8192,
  parameter int DATA_W = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/gbs_lane.sv =====
// ----------------------------------------------------------------------------
// gbs_lane
// One channel: pixel times tap weight, then accumulate over the window.
// ----------------------------------------------------------------------------
module gbs_lane #(
  parameter int WT_W  = 34,
  parameter int ACC_W = 48
) (
  input  logic                    clk,
  input  gbs_pkg::lane_ctl_t      ctl,
  input  logic [gbs_pkg::PIX_W-1:0] pix,
  input  logic [WT_W-1:0]         weight,
  output logic [ACC_W-1:0]        acc
);

  logic [WT_W+gbs_pkg::PIX_W-1:0] prod_r;
  logic [WT_W+gbs_pkg::PIX_W-1:0] prod_nxt;
  logic [ACC_W-1:0]               acc_r;

  // padding taps contribute nothing
  assign prod_nxt = ctl.tap_ok ? (WT_W+gbs_pkg::PIX_W)'(pix * weight) : '0;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.clr) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

// ===== hw/rtl/gbs_merge.sv =====
// ----------------------------------------------------------------------------
// gbs_merge
// Scale and saturate the lane sums and hold the result beat for the sink.
// ----------------------------------------------------------------------------
module gbs_merge #(
  parameter int CHANNELS = 3,
  parameter int ACC_W    = 48,
  parameter int SHIFT    = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [CHANNELS*ACC_W-1:0] acc_vec,
  input  logic                      last,
  output logic                      free,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_ch0,
  output logic [7:0]                out_ch1,
  output logic [7:0]                out_ch2,
  output logic                      out_frame_last
);

  logic [7:0] sat [3];
  logic [7:0] ch_r [3];
  logic       last_r;
  logic       valid_r;

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_sat
      if (g < CHANNELS) begin : g_live
        logic [ACC_W-1:0] shifted;
        assign shifted = acc_vec[g*ACC_W +: ACC_W] >> SHIFT;
        assign sat[g]  = (|shifted[ACC_W-1:8]) ? 8'hFF : shifted[7:0];
      end else begin : g_zero
        assign sat[g] = '0;
      end
    end
  endgenerate

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r[0] <= sat[0];
      ch_r[1] <= sat[1];
      ch_r[2] <= sat[2];
      last_r  <= last;
    end
  end

  assign out_valid      = valid_r;
  assign out_ch0        = ch_r[0];
  assign out_ch1        = ch_r[1];
  assign out_ch2        = ch_r[2];
  assign out_frame_last = last_r;

endmodule

// ===== hw/rtl/gaussian_blur_stream.sv =====
// Flow: an item that completes a window starts a walk through ST_RUN, ST_DRAIN and
// ST_FIN before its result is loaded into gbs_merge; other items are only stored.
// Input stalls until the walk returns to ST_IDLE; the single read port of the line
// store walks the window one tap per cycle.
// Reset: synchronous, active low; registers take their defaults, counters clear.
// ----------------------------------------------------------------------------
// gaussian_blur_stream
// Zero-padded separable Gaussian blur over raster pixels, one lane per channel.
// ----------------------------------------------------------------------------
`include "gaussian_blur_stream_macros.svh"

module gaussian_blur_stream #(
  parameter int MAX_RADIUS = gbs_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = gbs_pkg::DEF_MAX_WIDTH,
  parameter int CHANNELS   = gbs_pkg::DEF_CHANNELS,
  parameter int COEF_BITS  = gbs_pkg::DEF_COEF_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [7:0]                      in_pixel_ch0,
  input  logic [7:0]                      in_pixel_ch1,
  input  logic [7:0]                      in_pixel_ch2,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_ch0,
  output logic [7:0]                      out_ch1,
  output logic [7:0]                      out_ch2,
  output logic                            out_frame_last
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int OW    = RW + 1;
  localparam int RING  = 2 * MAX_RADIUS + 2;
  localparam int RGW   = $clog2(RING);
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int DLW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int CFW   = COEF_BITS + 1;
  localparam int WTW   = 2 * CFW;
  localparam int ACW   = WTW + gbs_pkg::PIX_W
                         + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));
  localparam int PW    = gbs_pkg::PIX_W * CHANNELS;
  localparam int XW    = CW + 2;
  localparam int YW    = gbs_pkg::ROW_W + 2;
  localparam int HW    = gbs_pkg::HGT_W;

  // configuration registers
  logic [10:0]                     image_width_r;
  logic [HW-1:0]                   image_height_r;
  logic [1:0]                      kernel_radius_r;
  logic [gbs_pkg::CFG_DATA_W-1:0]  coef_r [gbs_pkg::NUM_COEF];

  // position state
  logic [CW-1:0]            in_col_r;
  logic [RGW-1:0]           in_ring_r;
  logic [DLW-1:0]           item_cnt_r;
  logic [CW-1:0]            out_col_r;
  logic [gbs_pkg::ROW_W-1:0] out_row_r;
  logic [RGW-1:0]           out_ring_r;

  gbs_pkg::gbs_state_t      state_r, state_nxt;
  logic signed [OW-1:0]     dy_r, dx_r;
  logic                     drain_cnt_r;
  logic                     ok_s1_r;
  logic [WTW-1:0]           weight_s1_r;

  logic                     cfg_we, accept, due, last_tap, load, free, ended, rd_en;
  logic [WW-1:0]            w_eff;
  logic [HW-1:0]            h_eff;
  logic [RW-1:0]            r_eff;
  logic signed [OW-1:0]     r_s;
  logic [DLW-1:0]           delay_w;
  logic [CFW-1:0]           coef_eff [gbs_pkg::NUM_COEF];

  logic signed [YW-1:0]     ty;
  logic signed [XW-1:0]     tx;
  logic signed [RGW+1:0]    tr;
  logic signed [YW-1:0]     h_s;
  logic signed [XW-1:0]     w_s;
  logic [RGW-1:0]           rd_ring;
  logic                     x_ok, y_ok;
  logic [OW-1:0]            ady, adx;
  logic [CFW-1:0]           cy, cx;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [PW-1:0]            wr_data, rd_data;
  logic [7:0]               pix_in [3];
  logic [CHANNELS*ACW-1:0]  acc_vec;
  gbs_pkg::lane_ctl_t       lane_ctl;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = in_valid && !in_stall;

  // effective values of the registers
  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(image_height_r) > 32'(gbs_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(gbs_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    if (32'(kernel_radius_r) > 32'(MAX_RADIUS)) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(kernel_radius_r);
    end
    for (int i = 0; i < gbs_pkg::NUM_COEF; i++) begin
      if (32'(coef_r[i]) > (32'd1 << COEF_BITS)) begin
        coef_eff[i] = CFW'(32'd1 << COEF_BITS);
      end else begin
        coef_eff[i] = CFW'(coef_r[i]);
      end
    end
  end

  assign r_s     = $signed({1'b0, r_eff});
  assign delay_w = DLW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
  assign due     = item_cnt_r >= delay_w;
  assign ended   = (32'(out_row_r) + 32'd1 >= 32'(h_eff))
                && (32'(out_col_r) + 32'd1 >= 32'(w_eff));
  assign last_tap = (dy_r == r_s) && (dx_r == r_s);

  // write side
  assign pix_in[0] = in_pixel_ch0;
  assign pix_in[1] = in_pixel_ch1;
  assign pix_in[2] = in_pixel_ch2;

  always_comb begin
    wr_data = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < 3 && !in_action) begin
        wr_data[c*gbs_pkg::PIX_W +: gbs_pkg::PIX_W] = pix_in[c];
      end
    end
  end

  assign wr_addr = AW'(32'(in_ring_r) * MAX_WIDTH + 32'(in_col_r));

  // tap address and padding test
  assign h_s = YW'({1'b0, h_eff});
  assign w_s = XW'({1'b0, w_eff});
  assign ty  = $signed({2'b00, out_row_r}) + {{(YW-OW){dy_r[OW-1]}}, dy_r};
  assign tx  = $signed({2'b00, out_col_r}) + {{(XW-OW){dx_r[OW-1]}}, dx_r};
  assign tr  = $signed({2'b00, out_ring_r}) + {{(RGW+2-OW){dy_r[OW-1]}}, dy_r};
  assign y_ok = (ty >= 0) && (ty < h_s);
  assign x_ok = (tx >= 0) && (tx < w_s);

  always_comb begin
    if (tr < 0) begin
      rd_ring = RGW'(tr + (RGW+2)'(RING));
    end else if (tr >= (RGW+2)'(RING)) begin
      rd_ring = RGW'(tr - (RGW+2)'(RING));
    end else begin
      rd_ring = RGW'(tr);
    end
  end

  assign rd_addr = AW'(32'(rd_ring) * MAX_WIDTH + 32'(tx[CW-1:0]));

  assign ady = dy_r[OW-1] ? OW'(-dy_r) : OW'(dy_r);
  assign adx = dx_r[OW-1] ? OW'(-dx_r) : OW'(dx_r);
  assign cy  = coef_eff[2'(ady)];
  assign cx  = coef_eff[2'(adx)];

  // control FSM: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbs_pkg::ST_IDLE:  if (accept && due) state_nxt = gbs_pkg::ST_RUN;
      gbs_pkg::ST_RUN:   if (last_tap) state_nxt = gbs_pkg::ST_DRAIN;
      gbs_pkg::ST_DRAIN: if (drain_cnt_r) state_nxt = gbs_pkg::ST_FIN;
      gbs_pkg::ST_FIN:   if (free) state_nxt = gbs_pkg::ST_IDLE;
      default:           state_nxt = gbs_pkg::ST_IDLE;
    endcase
  end

  // control FSM: outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    load     = 1'b0;
    unique case (state_r)
      gbs_pkg::ST_IDLE:  in_stall = 1'b0;
      gbs_pkg::ST_RUN:   rd_en = 1'b1;
      gbs_pkg::ST_DRAIN: rd_en = 1'b0;
      gbs_pkg::ST_FIN:   load = free;
      default:           in_stall = 1'b1;
    endcase
  end

  assign lane_ctl.clr    = accept && due;
  assign lane_ctl.tap_ok = ok_s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbs_pkg::ST_IDLE;
      dy_r        <= '0;
      dx_r        <= '0;
      drain_cnt_r <= 1'b0;
      ok_s1_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_s1_r <= rd_en && x_ok && y_ok;
      if (state_r == gbs_pkg::ST_IDLE) begin
        dy_r <= -r_s;
        dx_r <= -r_s;
      end else if (rd_en) begin
        // walk the window row by row
        if (dx_r == r_s) begin
          dx_r <= -r_s;
          dy_r <= dy_r + OW'(1);
        end else begin
          dx_r <= dx_r + OW'(1);
        end
      end
      drain_cnt_r <= (state_r == gbs_pkg::ST_DRAIN) ? !drain_cnt_r : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    weight_s1_r <= WTW'(cy * cx);
  end

  // registers and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= gbs_pkg::RST_IMAGE_WIDTH;
      image_height_r  <= gbs_pkg::RST_IMAGE_HEIGHT;
      kernel_radius_r <= gbs_pkg::RST_KERNEL_RADIUS;
      coef_r[0]       <= gbs_pkg::RST_COEF_CENTER;
      coef_r[1]       <= gbs_pkg::RST_COEF_OFF1;
      coef_r[2]       <= gbs_pkg::RST_COEF_OFF2;
      coef_r[3]       <= gbs_pkg::RST_COEF_OFF3;
      in_col_r        <= '0;
      in_ring_r       <= '0;
      item_cnt_r      <= '0;
      out_col_r       <= '0;
      out_row_r       <= '0;
      out_ring_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbs_pkg::REG_IMAGE_WIDTH:   image_width_r   <= cfg_data[10:0];
        gbs_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[HW-1:0];
        gbs_pkg::REG_KERNEL_RADIUS: kernel_radius_r <= cfg_data[1:0];
        gbs_pkg::REG_COEF_CENTER:   coef_r[0]       <= cfg_data;
        gbs_pkg::REG_COEF_OFF1:     coef_r[1]       <= cfg_data;
        gbs_pkg::REG_COEF_OFF2:     coef_r[2]       <= cfg_data;
        gbs_pkg::REG_COEF_OFF3:     coef_r[3]       <= cfg_data;
        default:                    ;
      endcase
      // any write restarts the frame
      in_col_r   <= '0;
      in_ring_r  <= '0;
      item_cnt_r <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_ring_r <= '0;
    end else begin
      if (accept) begin
        if (!due) begin
          item_cnt_r <= item_cnt_r + DLW'(1);
        end
        if (32'(in_col_r) + 32'd1 >= 32'(w_eff)) begin
          in_col_r  <= '0;
          in_ring_r <= (32'(in_ring_r) == RING - 1) ? '0 : in_ring_r + RGW'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end
      if (load) begin
        if (ended) begin
          in_col_r   <= '0;
          in_ring_r  <= '0;
          item_cnt_r <= '0;
          out_col_r  <= '0;
          out_row_r  <= '0;
          out_ring_r <= '0;
        end else if (32'(out_col_r) + 32'd1 >= 32'(w_eff)) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + gbs_pkg::ROW_W'(1);
          out_ring_r <= (32'(out_ring_r) == RING - 1) ? '0 : out_ring_r + RGW'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

  gbs_line_store #(
    .DEPTH  (DEPTH),
    .DATA_W (PW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  genvar g;
  generate
    for (g = 0; g < CHANNELS; g++) begin : g_lane
      gbs_lane #(
        .WT_W  (WTW),
        .ACC_W (ACW)
      ) u_lane (
        .clk    (clk),
        .ctl    (lane_ctl),
        .pix    (rd_data[g*gbs_pkg::PIX_W +: gbs_pkg::PIX_W]),
        .weight (weight_s1_r),
        .acc    (acc_vec[g*ACW +: ACW])
      );
    end
  endgenerate

  gbs_merge #(
    .CHANNELS (CHANNELS),
    .ACC_W    (ACW),
    .SHIFT    (2 * COEF_BITS)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .acc_vec        (acc_vec),
    .last           (ended),
    .free           (free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ch0        (out_ch0),
    .out_ch1        (out_ch1),
    .out_ch2        (out_ch2),
    .out_frame_last (out_frame_last)
  );

  `GBS_ASSERT_NXT(a_due_starts_run, accept && due && !cfg_we, state_r == gbs_pkg::ST_RUN, "due item did not start the window walk")
  `GBS_ASSERT_IMP(a_load_slot_free, load, !(out_valid && out_stall), "result loaded over a held beat")
  `GBS_ASSERT_IMP(a_cnt_bound, 1'b1, item_cnt_r <= delay_w, "item count ran past the window delay")
  `GBS_ASSERT_IMP(a_tap_in_walk, ok_s1_r, state_r == gbs_pkg::ST_RUN || state_r == gbs_pkg::ST_DRAIN, "tap flagged outside the window walk")

endmodule
